// ----- sv/asf_pkg.sv -----
// Shared types and constants of the switchover finder.
package asf_pkg;
   localparam int SIZE_W     = 33;
   localparam int TH_W       = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SHAMT_W    = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWITCH_TH = 2'd0,
      CSR_BACK_TH   = 2'd1,
      CSR_THREE_ALG = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_idx_type;

   localparam logic [TH_W-1:0] TH_RESET = 16'd6554;
endpackage

// ----- sv/asf_if.sv -----
// Request and response channel interfaces.
interface asf_req_if #(parameter int TIME_BITS = 48);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] time_first;
   logic [TIME_BITS-1:0] time_second;
   logic [TIME_BITS-1:0] time_third;
   logic                 last_sample;
   modport source (output valid, time_first, time_second, time_third, last_sample,
                   input ready);
   modport sink (input valid, time_first, time_second, time_third, last_sample,
                 output ready);
endinterface

interface asf_rsp_if;
   logic        valid;
   logic        ready;
   logic [32:0] first_switch_size;
   logic [32:0] second_switch_size;
   logic        sample_overflow;
   modport source (output valid, first_switch_size, second_switch_size, sample_overflow,
                   input ready);
   modport sink (input valid, first_switch_size, second_switch_size, sample_overflow,
                 output ready);
endinterface

// ----- sv/asf_cell.sv -----
// One sample cell of the shift chain: holds the three times of one size.
module asf_cell #(
   parameter int TIME_BITS = 48
) (
   input  logic                   clock,
   input  logic                   shift,
   input  logic [3*TIME_BITS-1:0] data_in,
   output logic [3*TIME_BITS-1:0] data_out
);
   logic [3*TIME_BITS-1:0] data_ff;
   logic [3*TIME_BITS-1:0] data_in_mux;

   assign data_in_mux = shift ? data_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in_mux;
   end

   assign data_out = data_ff;
endmodule

// ----- sv/asf_pair.sv -----
// Streaming switchover analysis of one algorithm pair, two stages.
module asf_pair
   import asf_pkg::*;
#(
   parameter int TIME_BITS = 48,
   parameter int IDX_W     = 5,
   parameter int CNT_W     = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 in_valid,
   input  logic [IDX_W-1:0]     idx,
   input  logic [TIME_BITS-1:0] x,
   input  logic [TIME_BITS-1:0] y,
   input  logic [TH_W-1:0]      th_switch,
   input  logic [TH_W-1:0]      th_back,
   input  logic [CNT_W-1:0]     n,
   output logic [SIZE_W-1:0]    point
);
   localparam int PW = TIME_BITS + TH_W;

   logic                 slow;
   logic [TIME_BITS-1:0] big;
   logic [TIME_BITS-1:0] diff;
   logic                 s1_valid_ff;
   logic                 s1_slow_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [PW-1:0]        s1_lhs_ff;
   logic [PW-1:0]        s1_prs_ff;
   logic [PW-1:0]        s1_prb_ff;
   logic                 gain_sw;
   logic                 gain_bk;
   logic                 cand_ff, cand_in;
   logic                 have_k_ff, have_k_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [SHAMT_W-1:0]   kshift;

   assign slow = x > y;
   assign big  = slow ? x : y;
   assign diff = slow ? (x - y) : (y - x);

   always_ff @(posedge clock) begin
      s1_slow_ff <= slow;
      s1_idx_ff  <= idx;
      s1_lhs_ff  <= {diff, {TH_W{1'b0}}};
      s1_prs_ff  <= PW'(big) * PW'(th_switch);
      s1_prb_ff  <= PW'(big) * PW'(th_back);
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   assign gain_sw = s1_lhs_ff > s1_prs_ff;
   assign gain_bk = s1_lhs_ff > s1_prb_ff;

   always_comb begin
      cand_in   = cand_ff;
      have_k_in = have_k_ff;
      k_in      = k_ff;
      if (clear) begin
         cand_in   = 1'b0;
         have_k_in = 1'b0;
      end else if (s1_valid_ff) begin
         if (!s1_slow_ff) begin
            have_k_in = 1'b1;
            k_in      = s1_idx_ff;
         end
         if (!cand_ff) begin
            cand_in = s1_slow_ff && gain_sw;
         end else if (!s1_slow_ff && gain_bk) begin
            cand_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (reset) begin
         cand_ff   <= 1'b0;
         have_k_ff <= 1'b0;
      end else begin
         cand_ff   <= cand_in;
         have_k_ff <= have_k_in;
      end
   end

   assign kshift = (cand_ff && have_k_ff) ? (SHAMT_W'(k_ff) + SHAMT_W'(1)) : SHAMT_W'(n);
   assign point  = SIZE_W'(1) << kshift;
endmodule

// ----- sv/algorithm_switchover_finder.sv -----
// Top level of the switchover finder.
// Requests on req_if carry the A, B and C times of one power-of-two size,
// size 1<<i for the i-th request of a set. One request is taken per cycle
// while loading; each is shifted into a chain of MAX_SAMPLES cells.
// A request with last_sample closes the set: req_if.ready drops, the chain
// shifts on until sample 0 is at the head, then streams n samples through
// three pair analyzers (A/B, B/C, A/C), one per cycle.
// One response per set on rsp_if; it holds until taken, and no request is
// taken meanwhile. Requests beyond MAX_SAMPLES are dropped and flagged.
// csr_* writes thresholds and the mode; write only while idle.
// Reset (synchronous) empties the set and restores default thresholds.
module algorithm_switchover_finder
   import asf_pkg::*;
#(
   parameter int MAX_SAMPLES = 32,
   parameter int TIME_BITS   = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   asf_req_if.sink               req_if,
   asf_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DW    = 3 * TIME_BITS;

   typedef enum logic [2:0] {LOAD, ALIGN, STREAM, FLUSH, LATCH, OUT} state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    pos_ff;
   logic                ovf_ff;
   logic [TH_W-1:0]     th_sw_ff, th_bk_ff;
   logic                three_ff;
   logic [SIZE_W-1:0]   first_ff, second_ff;
   logic                rsp_ovf_ff;
   logic                req_acc, store, shift, clear, stream_v;
   logic [DW-1:0]       chain [MAX_SAMPLES+1];
   logic [TIME_BITS-1:0] ha, hb, hc;
   logic [SIZE_W-1:0]   p_ab, p_bc, p_ac;

   assign req_acc = req_if.valid && req_if.ready && (state_ff == LOAD);
   assign store   = req_acc && (cnt_ff != CNT_W'(MAX_SAMPLES));
   assign stream_v = (state_ff == STREAM);
   assign shift   = store || (state_ff == ALIGN && pos_ff != CNT_W'(MAX_SAMPLES)) || stream_v;
   assign clear   = req_acc && req_if.last_sample;

   assign chain[0] = {req_if.time_third, req_if.time_second, req_if.time_first};

   for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
      asf_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock   (clock),
         .shift   (shift),
         .data_in (chain[g]),
         .data_out(chain[g+1])
      );
   end

   assign ha = chain[MAX_SAMPLES][TIME_BITS-1:0];
   assign hb = chain[MAX_SAMPLES][2*TIME_BITS-1:TIME_BITS];
   assign hc = chain[MAX_SAMPLES][DW-1:2*TIME_BITS];

   asf_pair #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ab (
      .clock(clock), .reset(reset), .clear(clear), .in_valid(stream_v),
      .idx(pos_ff[IDX_W-1:0]), .x(ha), .y(hb), .th_switch(th_sw_ff),
      .th_back(th_bk_ff), .n(cnt_ff), .point(p_ab));
   asf_pair #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_bc (
      .clock(clock), .reset(reset), .clear(clear), .in_valid(stream_v),
      .idx(pos_ff[IDX_W-1:0]), .x(hb), .y(hc), .th_switch(th_sw_ff),
      .th_back(th_bk_ff), .n(cnt_ff), .point(p_bc));
   asf_pair #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ac (
      .clock(clock), .reset(reset), .clear(clear), .in_valid(stream_v),
      .idx(pos_ff[IDX_W-1:0]), .x(ha), .y(hc), .th_switch(th_sw_ff),
      .th_back(th_bk_ff), .n(cnt_ff), .point(p_ac));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LOAD;
         cnt_ff     <= '0;
         pos_ff     <= '0;
         ovf_ff     <= 1'b0;
         th_sw_ff   <= TH_RESET;
         th_bk_ff   <= TH_RESET;
         three_ff   <= 1'b0;
         rsp_ovf_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx_type'(csr_idx))
               CSR_SWITCH_TH: th_sw_ff <= csr_wdata[TH_W-1:0];
               CSR_BACK_TH:   th_bk_ff <= csr_wdata[TH_W-1:0];
               CSR_THREE_ALG: three_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            LOAD: begin
               if (req_acc) begin
                  if (store) begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_if.last_sample) begin
                     pos_ff   <= store ? (cnt_ff + CNT_W'(1)) : cnt_ff;
                     state_ff <= ALIGN;
                  end
               end
            end
            ALIGN: begin
               if (pos_ff == CNT_W'(MAX_SAMPLES)) begin
                  pos_ff   <= '0;
                  state_ff <= STREAM;
               end else begin
                  pos_ff <= pos_ff + CNT_W'(1);
               end
            end
            STREAM: begin
               pos_ff <= pos_ff + CNT_W'(1);
               if (pos_ff == cnt_ff - CNT_W'(1)) begin
                  state_ff <= FLUSH;
               end
            end
            FLUSH: state_ff <= LATCH;
            LATCH: begin
               rsp_ovf_ff <= ovf_ff;
               state_ff   <= OUT;
            end
            OUT: begin
               if (rsp_if.ready) begin
                  cnt_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= LOAD;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == LATCH) begin
         if (!three_ff) begin
            first_ff  <= p_ab;
            second_ff <= '0;
         end else if (p_bc < p_ab) begin
            first_ff  <= p_ac;
            second_ff <= p_ac;
         end else begin
            first_ff  <= p_ab;
            second_ff <= p_bc;
         end
      end
   end

   assign req_if.ready              = (state_ff == LOAD);
   assign rsp_if.valid              = (state_ff == OUT);
   assign rsp_if.first_switch_size  = first_ff;
   assign rsp_if.second_switch_size = second_ff;
   assign rsp_if.sample_overflow    = rsp_ovf_ff;
endmodule

// ----- sv/asf_checker.sv -----
// Port-level checks of the switchover finder, bound to the top level.
module asf_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [32:0] first_size
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> first_size != 33'd0)
      else $error("zero switchover size");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response repeated");
endmodule

bind algorithm_switchover_finder asf_checker u_asf_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .first_size(rsp_if.first_switch_size)
);
